FILE: design/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared types, constants and helpers of the keystroke sequence matcher.
// ----------------------------------------------------------------------------
package ksm_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int MAX_ARGS_DEF    = 8;

	localparam int SYM_BITS  = 5;
	localparam int SYM_COUNT = 32;
	localparam int CASE_GAP  = 32;
	localparam int BYTE_BITS = 8;

	localparam logic [7:0] KEY_UPPER_A = 8'h41;
	localparam logic [7:0] KEY_UPPER_Z = 8'h5A;
	localparam logic [7:0] KEY_LOWER_A = 8'h61;
	localparam logic [7:0] KEY_SYM_TOP = 8'(97 + SYM_COUNT - 1);

	typedef enum logic {
		OP_KEY  = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef logic [7:0]         key_t;
	typedef logic [4:0]         ctx_t;
	typedef logic [5:0]         slot_t;
	typedef logic [63:0]        word64_t;
	typedef logic signed [8:0]  arg_t;
	typedef logic [3:0]         cnt4_t;
	typedef logic [6:0]         tsize_t;

	typedef struct packed {
		word64_t code;
		word64_t mask;
		ctx_t    forbid;
		arg_t    arg;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic key_t lower_key(input key_t k);
		key_t r;
		r = k;
		if (k >= KEY_UPPER_A && k <= KEY_UPPER_Z) begin
			r = k + 8'(CASE_GAP);
		end
		return r;
	endfunction

endpackage

FILE: design/ksm_req_if.sv
// ----------------------------------------------------------------------------
// ksm_req_if
// Input channel: key strokes and table loads, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ksm_req_if;
	import ksm_pkg::*;

	logic    valid;
	logic    ready;
	logic    op;
	key_t    key_code;
	ctx_t    context_flags;
	slot_t   entry_index;
	word64_t entry_code;
	word64_t entry_mask;
	ctx_t    entry_forbid;
	arg_t    entry_arg;

	modport source (
		output valid, op, key_code, context_flags, entry_index,
		       entry_code, entry_mask, entry_forbid, entry_arg,
		input  ready
	);

	modport sink (
		input  valid, op, key_code, context_flags, entry_index,
		       entry_code, entry_mask, entry_forbid, entry_arg,
		output ready
	);

endinterface

FILE: design/ksm_rsp_if.sv
// ----------------------------------------------------------------------------
// ksm_rsp_if
// Output channel: one result word per input word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ksm_rsp_if;
	import ksm_pkg::*;

	logic    valid;
	logic    ready;
	logic    eaten;
	logic    fire;
	slot_t   fire_entry;
	arg_t    fire_value;
	logic    fire_with_args;
	word64_t arg_bytes;
	cnt4_t   arg_count;

	modport source (
		output valid, eaten, fire, fire_entry, fire_value, fire_with_args,
		       arg_bytes, arg_count,
		input  ready
	);

	modport sink (
		input  valid, eaten, fire, fire_entry, fire_value, fire_with_args,
		       arg_bytes, arg_count,
		output ready
	);

endinterface

FILE: design/ksm_ram.sv
// ----------------------------------------------------------------------------
// ksm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ksm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/keystroke_sequence_matcher_top.sv
// ----------------------------------------------------------------------------
// keystroke_sequence_matcher_top
// Key history matcher over a table of masked 5-bit symbol patterns.
// ----------------------------------------------------------------------------
// usage
//  req carries key strokes (op 0) and table loads (op 1); rsp returns exactly
//  one result word per request word, in order.
//  cfg_we/cfg_wdata set table_size; write it only while the block is idle.
//  a load, a rejected key or a key stored as an argument byte goes from
//  accept straight to the emit step; a key that ends a collection passes the arg step first.
//  a symbol key walks the table one entry per cycle through the single
//  read port of the table ram over min(table_size, TABLE_DEPTH) entries,
//  then drains; it goes straight to emit when table_size is zero.
//  one word is in flight at a time; req.ready is high only while idle.
//  the result sits in an output register, so a stalled rsp holds the next
//  result in the emit step until the register frees.
//  reset clears history, argument collection and table_size; the table ram
//  is not cleared and entries must be loaded before they are searched.
// ----------------------------------------------------------------------------
module keystroke_sequence_matcher_top #(
	parameter int TABLE_DEPTH = ksm_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_ARGS    = ksm_pkg::MAX_ARGS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ksm_req_if.sink          req,
	ksm_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  ksm_pkg::tsize_t  cfg_wdata
);
	import ksm_pkg::*;

	localparam int AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_ARG,
		S_EMIT
	} state_t;

	state_t          state_q;
	tsize_t          tsize_q;
	word64_t         hist_q;
	ctx_t            ctx_q;
	logic [CW-1:0]   n_q;
	logic [AW-1:0]   idx_q;
	logic            vld_s1;
	logic [AW-1:0]   idx_s1;
	cnt4_t           left_q;
	slot_t           pend_q;
	word64_t         astore_q;
	cnt4_t           afill_q;

	logic            res_eaten_q, res_fire_q, res_wargs_q;
	slot_t           res_entry_q;
	arg_t            res_value_q;
	word64_t         res_bytes_q;
	cnt4_t           res_count_q;

	logic            out_valid_q, out_eaten_q, out_fire_q, out_wargs_q;
	slot_t           out_entry_q;
	arg_t            out_value_q;
	word64_t         out_bytes_q;
	cnt4_t           out_count_q;

	logic            accept;
	key_t            lk;
	logic            sym_ok;
	logic [4:0]      sym;
	logic            last_byte;
	word64_t         astore_nxt;
	cnt4_t           afill_nxt;
	logic [CW-1:0]   n_nxt;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t          wr_entry, rd_entry;

	logic            hit;
	logic [8:0]      arg_u;
	logic [9:0]      cnt10;
	cnt4_t           cnt;
	logic            emit_ok;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign lk     = lower_key(req.key_code);
	assign sym_ok = (lk >= KEY_LOWER_A) && (lk <= KEY_SYM_TOP);
	assign sym    = 5'(lk - KEY_LOWER_A);

	assign last_byte  = (left_q == 4'd1);
	assign astore_nxt = astore_q | (64'(lk) << {afill_q[2:0], 3'b000});
	assign afill_nxt  = afill_q + 4'd1;

	assign n_nxt = (32'(tsize_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(tsize_q);

	assign wr_entry = '{
		code:   req.entry_code,
		mask:   req.entry_mask,
		forbid: req.entry_forbid,
		arg:    req.entry_arg
	};

	assign ram_we    = accept && (req.op == OP_LOAD) && (32'(req.entry_index) < TABLE_DEPTH);
	assign ram_waddr = AW'(req.entry_index);
	assign ram_re    = (state_q == S_SCAN) ||
	                   (accept && (req.op == OP_KEY) && (left_q != 4'd0) && last_byte);
	assign ram_raddr = (state_q == S_SCAN) ? idx_q : AW'(pend_q);

	ksm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);
	assign hit      = ((hist_q & rd_entry.mask) == rd_entry.code) &&
	                  ((rd_entry.forbid & ctx_q) == 5'd0);
	assign arg_u    = rd_entry.arg;
	assign cnt10    = 10'd512 - {1'b0, arg_u};
	assign cnt      = (cnt10 > 10'(MAX_ARGS)) ? 4'(MAX_ARGS) : cnt10[3:0];

	assign emit_ok = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tsize_q     <= '0;
			hist_q      <= '0;
			ctx_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			left_q      <= '0;
			pend_q      <= '0;
			astore_q    <= '0;
			afill_q     <= '0;
			res_eaten_q <= 1'b0;
			res_fire_q  <= 1'b0;
			res_wargs_q <= 1'b0;
			res_entry_q <= '0;
			res_value_q <= '0;
			res_bytes_q <= '0;
			res_count_q <= '0;
			out_valid_q <= 1'b0;
			out_eaten_q <= 1'b0;
			out_fire_q  <= 1'b0;
			out_wargs_q <= 1'b0;
			out_entry_q <= '0;
			out_value_q <= '0;
			out_bytes_q <= '0;
			out_count_q <= '0;
		end else begin
			if (cfg_we) begin
				tsize_q <= cfg_wdata;
			end

			if (rsp.valid && rsp.ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end

			vld_s1 <= (state_q == S_SCAN);
			idx_s1 <= idx_q;

			// table walk, one entry back from the ram each cycle
			if (vld_s1 && hit) begin
				if (arg_u[8]) begin
					pend_q      <= 6'(idx_s1);
					left_q      <= cnt;
					astore_q    <= '0;
					afill_q     <= '0;
					res_eaten_q <= 1'b1;
				end else if (!res_fire_q) begin
					res_eaten_q <= 1'b1;
					res_fire_q  <= 1'b1;
					res_entry_q <= 6'(idx_s1);
					res_value_q <= rd_entry.arg;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_eaten_q <= 1'b0;
						res_fire_q  <= 1'b0;
						res_wargs_q <= 1'b0;
						res_entry_q <= '0;
						res_value_q <= '0;
						res_bytes_q <= '0;
						res_count_q <= '0;
						ctx_q       <= req.context_flags;
						idx_q       <= '0;
						n_q         <= n_nxt;
						state_q     <= S_EMIT;
						if (req.op == OP_KEY) begin
							if (left_q != 4'd0) begin
								// argument byte
								res_eaten_q <= 1'b1;
								left_q      <= left_q - 4'd1;
								if (last_byte) begin
									res_fire_q  <= 1'b1;
									res_wargs_q <= 1'b1;
									res_entry_q <= pend_q;
									res_bytes_q <= astore_nxt;
									res_count_q <= afill_nxt;
									astore_q    <= '0;
									afill_q     <= '0;
									state_q     <= S_ARG;
								end else begin
									astore_q <= astore_nxt;
									afill_q  <= afill_nxt;
								end
							end else if (!sym_ok) begin
								hist_q <= '0;
							end else begin
								hist_q <= {hist_q[63-SYM_BITS:0], sym};
								if (n_nxt != '0) begin
									state_q <= S_SCAN;
								end
							end
						end
					end
				end
				S_SCAN: begin
					if (CW'(idx_q) == n_q - CW'(1)) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_EMIT;
				end
				S_ARG: begin
					res_value_q <= rd_entry.arg;
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						out_eaten_q <= res_eaten_q;
						out_fire_q  <= res_fire_q;
						out_wargs_q <= res_wargs_q;
						out_entry_q <= res_entry_q;
						out_value_q <= res_value_q;
						out_bytes_q <= res_bytes_q;
						out_count_q <= res_count_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.eaten          = out_eaten_q;
	assign rsp.fire           = out_fire_q;
	assign rsp.fire_entry     = out_entry_q;
	assign rsp.fire_value     = out_value_q;
	assign rsp.fire_with_args = out_wargs_q;
	assign rsp.arg_bytes      = out_bytes_q;
	assign rsp.arg_count      = out_count_q;

endmodule
